FILE: hw/rtl/prdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prdf_pkg: shared types and constants of the Pollard rho divisor finder
// Number width, operation codes between controller and datapath, the status
// codes of a result and the table of Miller-Rabin witness bases.
// ----------------------------------------------------------------------------
package prdf_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int CNT_W     = $clog2(NUM_WIDTH);
    localparam int IN_W      = 64;
    localparam int DIV_CNT_W = $clog2(IN_W);
    localparam int OUT_W     = 64;

    localparam int BATCH_W = 11;
    localparam logic [BATCH_W-1:0] BATCH_RESET = 11'd128;
    localparam logic [BATCH_W-1:0] BATCH_MAX   = 11'd1024;

    localparam int NUM_BASES = 12;
    localparam int BIDX_W    = 4;
    localparam int BASE_W    = 6;

    typedef enum logic [1:0] {
        ST_PRIME   = 2'd0,
        ST_FACTOR  = 2'd1,
        ST_RETRY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MOD_BASE,
        OP_MOD_C,
        OP_MR_INIT,
        OP_SHIFT_D,
        OP_X_ONE,
        OP_SQ_X,
        OP_MUL_XB,
        OP_X_FROM_MM,
        OP_RHO_INIT,
        OP_SQ_T,
        OP_ADDC_T,
        OP_SQ_H,
        OP_ADDC_H,
        OP_MUL_P,
        OP_TAKE_Q,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_SWAP,
        OP_EMIT_INVALID,
        OP_EMIT_FOUR,
        OP_EMIT_PRIME,
        OP_EMIT_FACTOR,
        OP_EMIT_RETRY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BIDX_W-1:0] base_idx;
        logic [CNT_W-1:0]  bit_idx;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic n_lt2;
        logic n_eq4;
        logic rem_zero;
        logic n_eq_base;
        logic d_lsb;
        logic d_bit;
        logic x_eq1;
        logic x_eq_nm1;
        logic t_eq_h;
        logic q_zero;
        logic gb_zero;
        logic ga_gt1;
        logic out_free;
    } t_sts;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_TRIAL,
        S_TRIAL_W,
        S_MR_INIT,
        S_TWOS,
        S_BASE,
        S_POW_SQ,
        S_POW_SQ_W,
        S_POW_MUL,
        S_POW_MUL_W,
        S_POW_NEXT,
        S_MR_CHK,
        S_SQ_LOOP,
        S_SQ_W,
        S_SQ_CHK,
        S_BASE_NEXT,
        S_RHO_C,
        S_RHO_C_W,
        S_BATCH,
        S_STEP,
        S_T_W,
        S_H1,
        S_H1_W,
        S_H2,
        S_H2_W,
        S_CMP,
        S_P_W,
        S_GCD_INIT,
        S_GCD,
        S_GCD_W,
        S_GCD_END
    } t_state;

    // Witness bases 2 through 37, also used for trial division.
    function automatic logic [BASE_W-1:0] mr_base(input logic [BIDX_W-1:0] idx);
        logic [BASE_W-1:0] b;
        begin
            case (idx)
                4'd0:    b = 6'd2;
                4'd1:    b = 6'd3;
                4'd2:    b = 6'd5;
                4'd3:    b = 6'd7;
                4'd4:    b = 6'd11;
                4'd5:    b = 6'd13;
                4'd6:    b = 6'd17;
                4'd7:    b = 6'd19;
                4'd8:    b = 6'd23;
                4'd9:    b = 6'd29;
                4'd10:   b = 6'd31;
                4'd11:   b = 6'd37;
                default: b = 6'd37;
            endcase
            return b;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/prdf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prdf_in_if / prdf_out_if: valid-ready channels of the divisor finder
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface prdf_in_if;
    logic                        valid;
    logic                        ready;
    logic [prdf_pkg::IN_W-1:0]   number;
    logic [prdf_pkg::IN_W-1:0]   increment;

    modport source (output valid, output number, output increment, input ready);
    modport sink   (input valid, input number, input increment, output ready);
endinterface

interface prdf_out_if;
    logic                        valid;
    logic                        ready;
    logic [prdf_pkg::OUT_W-1:0]  divisor;
    logic [1:0]                  status;

    modport source (output valid, output divisor, output status, input ready);
    modport sink   (input valid, input divisor, input status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/prdf_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prdf_dpath: datapath of the divisor finder
// Operand registers, a bit-serial modular multiplier, a bit-serial remainder
// unit and the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module prdf_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [prdf_pkg::IN_W-1:0]     i_number,
    input  wire logic [prdf_pkg::IN_W-1:0]     i_increment,
    input  wire prdf_pkg::t_cmd                i_cmd,
    output prdf_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [prdf_pkg::OUT_W-1:0]         o_divisor,
    output prdf_pkg::t_status                  o_status
);

    localparam int W    = prdf_pkg::NUM_WIDTH;
    localparam int CW   = prdf_pkg::CNT_W;
    localparam int IW   = prdf_pkg::IN_W;
    localparam int DCW  = prdf_pkg::DIV_CNT_W;
    localparam int OW   = prdf_pkg::OUT_W;

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] n);
        logic [W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, n}) s = s - {1'b0, n};
            return s[W-1:0];
        end
    endfunction

    logic [W-1:0]  r_n, r_c, r_d, r_x, r_t, r_h, r_p, r_ga, r_gb;
    logic [IW-1:0] r_craw;

    logic          r_mm_busy, r_mm_phase;
    logic [CW-1:0] r_mm_cnt;
    logic [W-1:0]  r_mm_a, r_mm_b, r_mm_acc;

    logic           r_dv_busy;
    logic [DCW-1:0] r_dv_cnt;
    logic [IW-1:0]  r_dv_a;
    logic [W-1:0]   r_dv_b, r_dv_rem;

    logic              r_out_valid;
    logic [OW-1:0]     r_divisor;
    prdf_pkg::t_status r_status;

    logic [W-1:0] base_w, diff;
    logic [W:0]   dv_trial;
    logic         out_free;

    assign base_w   = W'(prdf_pkg::mr_base(i_cmd.base_idx));
    assign diff     = (r_t > r_h) ? (r_t - r_h) : (r_h - r_t);
    assign dv_trial = {r_dv_rem, r_dv_a[IW-1]};
    assign out_free = !r_out_valid || i_out_ready;

    // Operand registers and command decode.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_n    <= i_number[W-1:0];
            r_craw <= i_increment;
        end
        case (i_cmd.op)
            prdf_pkg::OP_MR_INIT:   r_d <= r_n - W'(1);
            prdf_pkg::OP_SHIFT_D:   r_d <= r_d >> 1;
            prdf_pkg::OP_X_ONE:     r_x <= W'(1);
            prdf_pkg::OP_X_FROM_MM: r_x <= r_mm_acc;
            prdf_pkg::OP_RHO_INIT: begin
                r_c <= r_dv_rem;
                r_t <= '0;
                r_h <= '0;
                r_p <= W'(1);
            end
            prdf_pkg::OP_ADDC_T:   r_t <= add_mod(r_mm_acc, r_c, r_n);
            prdf_pkg::OP_ADDC_H:   r_h <= add_mod(r_mm_acc, r_c, r_n);
            prdf_pkg::OP_TAKE_Q:   r_p <= r_mm_acc;
            prdf_pkg::OP_GCD_INIT: begin
                r_ga <= r_p;
                r_gb <= r_n;
            end
            prdf_pkg::OP_GCD_SWAP: begin
                r_ga <= r_gb;
                r_gb <= r_dv_rem;
            end
            default: ;
        endcase
    end

    // Modular multiplier: double-and-add over b from its top bit; each bit doubles the accumulator, then adds a if set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_busy <= 1'b0;
        end else if (r_mm_busy) begin
            r_mm_phase <= !r_mm_phase;
            if (!r_mm_phase) begin
                r_mm_acc <= add_mod(r_mm_acc, r_mm_acc, r_n);
            end else begin
                if (r_mm_b[W-1]) r_mm_acc <= add_mod(r_mm_acc, r_mm_a, r_n);
                r_mm_b   <= r_mm_b << 1;
                r_mm_cnt <= r_mm_cnt - CW'(1);
                if (r_mm_cnt == '0) r_mm_busy <= 1'b0;
            end
        end else begin
            case (i_cmd.op)
                prdf_pkg::OP_SQ_X, prdf_pkg::OP_MUL_XB, prdf_pkg::OP_SQ_T,
                prdf_pkg::OP_SQ_H, prdf_pkg::OP_MUL_P: begin
                    r_mm_busy  <= 1'b1;
                    r_mm_phase <= 1'b0;
                    r_mm_cnt   <= CW'(W - 1);
                    r_mm_acc   <= '0;
                end
                default: ;
            endcase
            case (i_cmd.op)
                prdf_pkg::OP_SQ_X: begin
                    r_mm_a <= r_x;
                    r_mm_b <= r_x;
                end
                prdf_pkg::OP_MUL_XB: begin
                    r_mm_a <= base_w;
                    r_mm_b <= r_x;
                end
                prdf_pkg::OP_SQ_T: begin
                    r_mm_a <= r_t;
                    r_mm_b <= r_t;
                end
                prdf_pkg::OP_SQ_H: begin
                    r_mm_a <= r_h;
                    r_mm_b <= r_h;
                end
                prdf_pkg::OP_MUL_P: begin
                    r_mm_a <= r_p;
                    r_mm_b <= diff;
                end
                default: ;
            endcase
        end
    end

    // Remainder unit: restoring division, one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
        end else if (r_dv_busy) begin
            if (dv_trial >= {1'b0, r_dv_b}) begin
                r_dv_rem <= W'(dv_trial - {1'b0, r_dv_b});
            end else begin
                r_dv_rem <= dv_trial[W-1:0];
            end
            r_dv_a   <= r_dv_a << 1;
            r_dv_cnt <= r_dv_cnt - DCW'(1);
            if (r_dv_cnt == '0) r_dv_busy <= 1'b0;
        end else begin
            case (i_cmd.op)
                prdf_pkg::OP_MOD_BASE, prdf_pkg::OP_MOD_C, prdf_pkg::OP_GCD_STEP: begin
                    r_dv_busy <= 1'b1;
                    r_dv_cnt  <= DCW'(IW - 1);
                    r_dv_rem  <= '0;
                end
                default: ;
            endcase
            case (i_cmd.op)
                prdf_pkg::OP_MOD_BASE: begin
                    r_dv_a <= IW'(r_n);
                    r_dv_b <= base_w;
                end
                prdf_pkg::OP_MOD_C: begin
                    r_dv_a <= r_craw;
                    r_dv_b <= r_n;
                end
                prdf_pkg::OP_GCD_STEP: begin
                    r_dv_a <= IW'(r_ga);
                    r_dv_b <= r_gb;
                end
                default: ;
            endcase
        end
    end

    // Result register; a new result may replace one taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                prdf_pkg::OP_EMIT_INVALID: begin
                    r_out_valid <= 1'b1;
                    r_divisor   <= '0;
                    r_status    <= prdf_pkg::ST_INVALID;
                end
                prdf_pkg::OP_EMIT_FOUR: begin
                    r_out_valid <= 1'b1;
                    r_divisor   <= OW'(2);
                    r_status    <= prdf_pkg::ST_FACTOR;
                end
                prdf_pkg::OP_EMIT_PRIME: begin
                    r_out_valid <= 1'b1;
                    r_divisor   <= OW'(r_n);
                    r_status    <= prdf_pkg::ST_PRIME;
                end
                prdf_pkg::OP_EMIT_FACTOR: begin
                    r_out_valid <= 1'b1;
                    r_divisor   <= OW'(r_ga);
                    r_status    <= prdf_pkg::ST_FACTOR;
                end
                prdf_pkg::OP_EMIT_RETRY: begin
                    r_out_valid <= 1'b1;
                    r_divisor   <= '0;
                    r_status    <= prdf_pkg::ST_RETRY;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.busy      = r_mm_busy || r_dv_busy;
        o_sts.n_lt2     = r_n < W'(2);
        o_sts.n_eq4     = r_n == W'(4);
        o_sts.rem_zero  = r_dv_rem == '0;
        o_sts.n_eq_base = r_n == base_w;
        o_sts.d_lsb     = r_d[0];
        o_sts.d_bit     = r_d[i_cmd.bit_idx];
        o_sts.x_eq1     = r_x == W'(1);
        o_sts.x_eq_nm1  = r_x == (r_n - W'(1));
        o_sts.t_eq_h    = r_t == r_h;
        o_sts.q_zero    = r_mm_acc == '0;
        o_sts.gb_zero   = r_gb == '0;
        o_sts.ga_gt1    = r_ga > W'(1);
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_divisor   = r_divisor;
    assign o_status    = r_status;

    a_mm_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_mm_busy) && $past(i_rst_n)) |-> (r_mm_acc < r_n))
        else $error("multiplier result not reduced");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mm_busy && r_dv_busy))
        else $error("multiplier and remainder unit busy together");

endmodule
`default_nettype wire

FILE: hw/rtl/prdf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prdf_ctrl: sequencer of the divisor finder
// Runs trial division, Miller-Rabin, the rho walk and the gcd by issuing
// commands to the datapath; holds the batch length register and loop counters.
// ----------------------------------------------------------------------------
module prdf_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_cfg_we,
    input  wire logic [prdf_pkg::BATCH_W-1:0]      i_cfg_data,
    input  wire prdf_pkg::t_sts                    i_sts,
    output prdf_pkg::t_cmd                         o_cmd
);

    localparam int CW = prdf_pkg::CNT_W;
    localparam int BW = prdf_pkg::BATCH_W;
    localparam int IW = prdf_pkg::BIDX_W;

    prdf_pkg::t_state r_state, n_state;
    prdf_pkg::t_op    r_emit, n_emit;
    logic [IW-1:0]    r_bidx, n_bidx;
    logic [CW-1:0]    r_k, n_k, r_s, n_s, r_j, n_j;
    logic [BW-1:0]    r_bcnt, n_bcnt;
    logic [BW-1:0]    r_batch_len;
    logic [BW-1:0]    len;
    logic             last_base;

    always_comb begin
        if (r_batch_len == '0)                      len = BW'(1);
        else if (r_batch_len > prdf_pkg::BATCH_MAX) len = prdf_pkg::BATCH_MAX;
        else                                        len = r_batch_len;
    end

    assign last_base = r_bidx == IW'(prdf_pkg::NUM_BASES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prdf_pkg::S_IDLE;
            r_batch_len <= prdf_pkg::BATCH_RESET;
            r_bcnt      <= '0;
        end else begin
            r_state <= n_state;
            r_bcnt  <= n_bcnt;
            if (i_cfg_we) r_batch_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit <= n_emit;
        r_bidx <= n_bidx;
        r_k    <= n_k;
        r_s    <= n_s;
        r_j    <= n_j;
    end

    always_comb begin
        n_state    = r_state;
        n_emit     = r_emit;
        n_bidx     = r_bidx;
        n_k        = r_k;
        n_s        = r_s;
        n_j        = r_j;
        n_bcnt     = r_bcnt;
        o_in_ready = 1'b0;
        o_cmd.op       = prdf_pkg::OP_NONE;
        o_cmd.base_idx = r_bidx;
        o_cmd.bit_idx  = r_k;

        case (r_state)
            prdf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = prdf_pkg::S_CHECK;
            end
            prdf_pkg::S_CHECK: begin
                if (i_sts.n_lt2) begin
                    n_emit = prdf_pkg::OP_EMIT_INVALID; n_state = prdf_pkg::S_GCD_END;
                end else if (i_sts.n_eq4) begin
                    n_emit = prdf_pkg::OP_EMIT_FOUR; n_state = prdf_pkg::S_GCD_END;
                end else begin
                    n_bidx  = '0;
                    n_state = prdf_pkg::S_TRIAL;
                end
            end
            prdf_pkg::S_TRIAL: begin
                o_cmd.op = prdf_pkg::OP_MOD_BASE;
                n_state  = prdf_pkg::S_TRIAL_W;
            end
            prdf_pkg::S_TRIAL_W: begin
                if (!i_sts.busy) begin
                    if (i_sts.rem_zero) begin
                        if (i_sts.n_eq_base) begin
                            n_emit = prdf_pkg::OP_EMIT_PRIME; n_state = prdf_pkg::S_GCD_END;
                        end else begin
                            n_state = prdf_pkg::S_RHO_C;
                        end
                    end else if (last_base) begin
                        n_state = prdf_pkg::S_MR_INIT;
                    end else begin
                        n_bidx  = r_bidx + IW'(1);
                        n_state = prdf_pkg::S_TRIAL;
                    end
                end
            end
            prdf_pkg::S_MR_INIT: begin
                o_cmd.op = prdf_pkg::OP_MR_INIT;
                n_s      = '0;
                n_state  = prdf_pkg::S_TWOS;
            end
            prdf_pkg::S_TWOS: begin
                if (!i_sts.d_lsb) begin
                    o_cmd.op = prdf_pkg::OP_SHIFT_D;
                    n_s      = r_s + CW'(1);
                end else begin
                    n_bidx  = '0;
                    n_state = prdf_pkg::S_BASE;
                end
            end
            prdf_pkg::S_BASE: begin
                o_cmd.op = prdf_pkg::OP_X_ONE;
                n_k      = CW'(prdf_pkg::NUM_WIDTH - 1);
                n_state  = prdf_pkg::S_POW_SQ;
            end
            prdf_pkg::S_POW_SQ: begin
                if (i_sts.x_eq1) begin
                    n_state = prdf_pkg::S_POW_MUL;
                end else begin
                    o_cmd.op = prdf_pkg::OP_SQ_X;
                    n_state  = prdf_pkg::S_POW_SQ_W;
                end
            end
            prdf_pkg::S_POW_SQ_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_X_FROM_MM;
                    n_state  = prdf_pkg::S_POW_MUL;
                end
            end
            prdf_pkg::S_POW_MUL: begin
                if (i_sts.d_bit) begin
                    o_cmd.op = prdf_pkg::OP_MUL_XB;
                    n_state  = prdf_pkg::S_POW_MUL_W;
                end else begin
                    n_state = prdf_pkg::S_POW_NEXT;
                end
            end
            prdf_pkg::S_POW_MUL_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_X_FROM_MM;
                    n_state  = prdf_pkg::S_POW_NEXT;
                end
            end
            prdf_pkg::S_POW_NEXT: begin
                if (r_k == '0) begin
                    n_state = prdf_pkg::S_MR_CHK;
                end else begin
                    n_k     = r_k - CW'(1);
                    n_state = prdf_pkg::S_POW_SQ;
                end
            end
            prdf_pkg::S_MR_CHK: begin
                if (i_sts.x_eq1 || i_sts.x_eq_nm1) begin
                    n_state = prdf_pkg::S_BASE_NEXT;
                end else begin
                    n_j     = CW'(1);
                    n_state = prdf_pkg::S_SQ_LOOP;
                end
            end
            prdf_pkg::S_SQ_LOOP: begin
                if (r_j >= r_s) begin
                    n_state = prdf_pkg::S_RHO_C;
                end else begin
                    o_cmd.op = prdf_pkg::OP_SQ_X;
                    n_state  = prdf_pkg::S_SQ_W;
                end
            end
            prdf_pkg::S_SQ_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_X_FROM_MM;
                    n_j      = r_j + CW'(1);
                    n_state  = prdf_pkg::S_SQ_CHK;
                end
            end
            prdf_pkg::S_SQ_CHK: begin
                n_state = i_sts.x_eq_nm1 ? prdf_pkg::S_BASE_NEXT : prdf_pkg::S_SQ_LOOP;
            end
            prdf_pkg::S_BASE_NEXT: begin
                if (last_base) begin
                    n_emit = prdf_pkg::OP_EMIT_PRIME; n_state = prdf_pkg::S_GCD_END;
                end else begin
                    n_bidx  = r_bidx + IW'(1);
                    n_state = prdf_pkg::S_BASE;
                end
            end
            prdf_pkg::S_RHO_C: begin
                o_cmd.op = prdf_pkg::OP_MOD_C;
                n_state  = prdf_pkg::S_RHO_C_W;
            end
            prdf_pkg::S_RHO_C_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_RHO_INIT;
                    n_state  = prdf_pkg::S_BATCH;
                end
            end
            prdf_pkg::S_BATCH: begin
                n_bcnt  = '0;
                n_state = prdf_pkg::S_STEP;
            end
            prdf_pkg::S_STEP: begin
                if (r_bcnt >= len) begin
                    n_state = prdf_pkg::S_GCD_INIT;
                end else begin
                    o_cmd.op = prdf_pkg::OP_SQ_T;
                    n_state  = prdf_pkg::S_T_W;
                end
            end
            prdf_pkg::S_T_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_ADDC_T;
                    n_state  = prdf_pkg::S_H1;
                end
            end
            prdf_pkg::S_H1: begin
                o_cmd.op = prdf_pkg::OP_SQ_H;
                n_state  = prdf_pkg::S_H1_W;
            end
            prdf_pkg::S_H1_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_ADDC_H;
                    n_state  = prdf_pkg::S_H2;
                end
            end
            prdf_pkg::S_H2: begin
                o_cmd.op = prdf_pkg::OP_SQ_H;
                n_state  = prdf_pkg::S_H2_W;
            end
            prdf_pkg::S_H2_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_ADDC_H;
                    n_bcnt   = r_bcnt + BW'(1);
                    n_state  = prdf_pkg::S_CMP;
                end
            end
            prdf_pkg::S_CMP: begin
                if (i_sts.t_eq_h) begin
                    n_state = prdf_pkg::S_GCD_INIT;
                end else begin
                    o_cmd.op = prdf_pkg::OP_MUL_P;
                    n_state  = prdf_pkg::S_P_W;
                end
            end
            prdf_pkg::S_P_W: begin
                if (!i_sts.busy) begin
                    if (i_sts.q_zero) begin
                        n_state = prdf_pkg::S_GCD_INIT;
                    end else begin
                        o_cmd.op = prdf_pkg::OP_TAKE_Q;
                        n_state  = prdf_pkg::S_STEP;
                    end
                end
            end
            prdf_pkg::S_GCD_INIT: begin
                o_cmd.op = prdf_pkg::OP_GCD_INIT;
                n_emit   = prdf_pkg::OP_NONE;
                n_state  = prdf_pkg::S_GCD;
            end
            prdf_pkg::S_GCD: begin
                if (i_sts.gb_zero) begin
                    if (i_sts.ga_gt1) begin
                        n_emit = prdf_pkg::OP_EMIT_FACTOR; n_state = prdf_pkg::S_GCD_END;
                    end else if (i_sts.t_eq_h) begin
                        n_emit = prdf_pkg::OP_EMIT_RETRY; n_state = prdf_pkg::S_GCD_END;
                    end else begin
                        n_state = prdf_pkg::S_BATCH;
                    end
                end else begin
                    o_cmd.op = prdf_pkg::OP_GCD_STEP;
                    n_state  = prdf_pkg::S_GCD_W;
                end
            end
            prdf_pkg::S_GCD_W: begin
                if (!i_sts.busy) begin
                    o_cmd.op = prdf_pkg::OP_GCD_SWAP;
                    n_state  = prdf_pkg::S_GCD;
                end
            end
            prdf_pkg::S_GCD_END: begin
                // Hand the decided result to the output register once it is free.
                if (i_sts.out_free) begin
                    o_cmd.op = r_emit;
                    n_state  = prdf_pkg::S_IDLE;
                end
            end
            default: n_state = prdf_pkg::S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == prdf_pkg::OP_EMIT_INVALID || o_cmd.op == prdf_pkg::OP_EMIT_FOUR ||
         o_cmd.op == prdf_pkg::OP_EMIT_PRIME || o_cmd.op == prdf_pkg::OP_EMIT_FACTOR ||
         o_cmd.op == prdf_pkg::OP_EMIT_RETRY) |-> i_sts.out_free)
        else $error("result issued while output register is occupied");

    a_no_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.busy |-> (o_cmd.op == prdf_pkg::OP_NONE))
        else $error("command issued while an arithmetic unit is busy");

    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prdf_pkg::S_STEP) |-> (r_bcnt <= len))
        else $error("batch counter beyond batch length");

endmodule
`default_nettype wire

FILE: hw/rtl/pollard_rho_divisor_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pollard_rho_divisor_finder: finds a nontrivial divisor of a 64-bit number
// Trial division, deterministic Miller-Rabin, then batched Pollard rho.
// ----------------------------------------------------------------------------
// Usage. The input channel i_in takes one beat carrying number and increment;
// the output channel o_out returns exactly one beat per input beat, carrying
// divisor and status (0 prime, 1 factor, 2 retry when the walk closes with no factor, 3 invalid).
// The block works on one item at a time: i_in.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next item is accepted while that result still waits to be taken; the new
// item's result is only written once the register is free.
// Cost. Each modular multiply runs on the shared double-and-add unit, each
// remainder on the restoring divider. Invalid numbers and four skip both
// units; trial division adds up to 12 remainders; Miller-Rabin costs up to
// 12 bases * 64 bits * 2 multiplies in the exponentiations, plus the final
// squarings. Each rho step is four multiplies, and each batch adds a gcd of
// up to roughly 95 remainder steps. The multiplier is the unit that sets the
// rate. Reset (i_rst_n low at a clock edge) returns the sequencer to idle,
// drops any pending result and sets batch_length to 128. The batch length
// register is written through i_cfg_we / i_cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pollard_rho_divisor_finder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    prdf_in_if.sink                            i_in,
    prdf_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [prdf_pkg::BATCH_W-1:0]  i_cfg_data
);

    prdf_pkg::t_cmd    cmd;
    prdf_pkg::t_sts    sts;
    prdf_pkg::t_status out_status;
    logic              in_ready;
    logic              in_accept;

    // A beat is taken only in the idle state of the sequencer.
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    prdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prdf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_number    (i_in.number),
        .i_increment (i_in.increment),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_divisor   (o_out.divisor),
        .o_status    (out_status)
    );

    assign o_out.status = out_status;

endmodule
`default_nettype wire

FILE: tb/prdf_checker.sv
// ----------------------------------------------------------------------------
// prdf_checker: result predictor and scoreboard of the divisor finder
// Watches the input, output and register channels, works out the answer of
// each accepted number and compares every returned beat with it.
// ----------------------------------------------------------------------------
module prdf_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    prdf_in_if                                 i_in,
    prdf_out_if                                i_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [prdf_pkg::BATCH_W-1:0]  i_cfg_data,
    output int                                 o_failures,
    output int                                 o_pending
);

    typedef struct {
        logic [63:0]       divisor;
        prdf_pkg::t_status status;
    } t_answer;

    t_answer                      answers_due[$];
    logic [prdf_pkg::BATCH_W-1:0] batch_len;

    function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n})
            s = s - {1'b0, n};
        return s[63:0];
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) % {64'd0, n};
        return p[63:0];
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] n);
        logic [63:0] r;
        r = 64'd1 % n;
        a = a % n;
        while (e != 0) begin
            if (e[0])
                r = mul_mod(r, a, n);
            a = mul_mod(a, a, n);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic [63:0] witness(int i);
        logic [63:0] w[prdf_pkg::NUM_BASES] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        return w[i];
    endfunction

    function automatic bit is_prime(logic [63:0] n);
        logic [63:0] d, x, b;
        int s;
        bit ok;
        s = 0;
        for (int i = 0; i < prdf_pkg::NUM_BASES; i++) begin
            b = witness(i);
            if (n % b == 0)
                return n == b;
        end
        d = n - 1;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < prdf_pkg::NUM_BASES; i++) begin
            x = pow_mod(witness(i), d, n);
            ok = (x == 1) || (x == n - 1);
            for (int k = 1; k < s && !ok; k++) begin
                x = mul_mod(x, x, n);
                if (x == n - 1)
                    ok = 1;
            end
            if (!ok)
                return 0;
        end
        return 1;
    endfunction

    function automatic logic [63:0] gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Answer for one number under the current batch length.
    function automatic t_answer find_divisor(logic [63:0] n, logic [63:0] inc,
                                             logic [prdf_pkg::BATCH_W-1:0] blen);
        t_answer a;
        logic [63:0] c, t, h, prod, diff, q, g;
        int len, cnt;
        if (n < 2) begin
            a.divisor = 0;
            a.status  = prdf_pkg::ST_INVALID;
            return a;
        end
        if (n == 4) begin
            a.divisor = 2;
            a.status  = prdf_pkg::ST_FACTOR;
            return a;
        end
        if (is_prime(n)) begin
            a.divisor = n;
            a.status  = prdf_pkg::ST_PRIME;
            return a;
        end
        c = inc % n;
        len = (blen == 0) ? 1 :
              (blen > prdf_pkg::BATCH_MAX) ? int'(prdf_pkg::BATCH_MAX) : int'(blen);
        t = 0;
        h = 0;
        prod = 1;
        forever begin
            cnt = 0;
            while (cnt < len) begin
                t = add_mod(mul_mod(t, t, n), c, n);
                h = add_mod(mul_mod(h, h, n), c, n);
                h = add_mod(mul_mod(h, h, n), c, n);
                cnt++;
                if (t == h)
                    break;
                diff = (t > h) ? t - h : h - t;
                q = mul_mod(prod, diff, n);
                // A zero product would hide the factor, so the batch ends here.
                if (q == 0)
                    break;
                prod = q;
            end
            g = gcd(prod, n);
            if (g > 1) begin
                a.divisor = g;
                a.status  = prdf_pkg::ST_FACTOR;
                return a;
            end
            if (t == h) begin
                a.divisor = 0;
                a.status  = prdf_pkg::ST_RETRY;
                return a;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            batch_len <= prdf_pkg::BATCH_RESET;
            answers_due.delete();
            o_failures <= 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_we)
                batch_len <= i_cfg_data;
            if (i_in.valid && i_in.ready)
                answers_due.push_back(find_divisor(i_in.number, i_in.increment, batch_len));
            if (i_out.valid && i_out.ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result beat: divisor %0d status %0d",
                           i_out.divisor, i_out.status);
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_out.divisor !== want.divisor) begin
                        $error("divisor: expected %0d, got %0d", want.divisor, i_out.divisor);
                        errs++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out.status);
                        errs++;
                    end
                end
            end
            o_failures <= o_failures + errs;
            o_pending  <= answers_due.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level of the divisor finder verification
// Drives directed and random numbers through the input channel under bursty
// traffic and a stalling receiver, walks the batch length register through
// several settings and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [prdf_pkg::BATCH_W-1:0] cfg_data;
    int                           failures;
    int                           pending;
    logic                         hold_req;
    logic                         hold_done;
    int                           hold_cnt;
    logic [31:0]                  cyc;
    int                           burst_left;

    prdf_in_if  in_ch ();
    prdf_out_if out_ch ();

    pollard_rho_divisor_finder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    prdf_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // The receiver cycles through stall patterns of its own: always ready,
    // coin flips, ready on a zero in the counter's low two bits, and mostly ready.
    // When the stimulus asks for it once, it refuses every beat for a long stretch
    // so that the output register fills and the block stops taking input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyc          <= '0;
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end else begin
            cyc <= cyc + 32'd1;
            if (hold_cnt != 0) begin
                out_ch.ready <= 1'b0;
                hold_cnt     <= hold_cnt - 1;
            end else if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                hold_cnt     <= 3000;
                hold_done    <= 1'b1;
            end else begin
                case (cyc[12:11])
                    2'd0: begin
                        out_ch.ready <= 1'b1;
                    end
                    2'd1: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    2'd2: begin
                        out_ch.ready <= (cyc[1:0] == 2'd0);
                    end
                    default: begin
                        out_ch.ready <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. The valid
    // line stays high while a burst lasts; otherwise it is lowered for a gap.
    task automatic send_number(logic [63:0] n, logic [63:0] inc);
        in_ch.valid     <= 1'b1;
        in_ch.number    <= n;
        in_ch.increment <= inc;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // Now and then a long run with no gaps at all.
            burst_left = ($urandom_range(0, 4) == 0) ? 20 : int'($urandom_range(0, 5));
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // The register is only written once the block has nothing in flight.
    task automatic set_batch_length(logic [prdf_pkg::BATCH_W-1:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Numbers are mostly small so that primality tests and the rho walk
    // stay short; large ones carry a factor of two or three and are left out
    // when batches are long and in the phase with batches of 33.
    function automatic logic [63:0] pick_number(bit allow_big);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 64'($urandom_range(0, 5));
        if (r < 30)
            return 64'($urandom_range(6, 1 << 12));
        if (r < 70 || !allow_big)
            return 64'($urandom_range(6, 1 << 20));
        if (r < 85)
            return {$urandom, $urandom} & ~64'd1;
        return ({$urandom, $urandom} >> 2) * 64'd3;
    endfunction

    function automatic logic [63:0] pick_increment(logic [63:0] n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 64'($urandom_range(1, 5));
        if (r == 2)
            return n * 64'($urandom_range(1, 3));
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(logic [prdf_pkg::BATCH_W-1:0] blen, int count, bit allow_big);
        logic [63:0] n;
        set_batch_length(blen);
        repeat (count) begin
            n = pick_number(allow_big);
            send_number(n, pick_increment(n));
        end
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.number    <= '0;
        in_ch.increment <= '0;
        cfg_we          <= 1'b0;
        cfg_data        <= '0;
        hold_req        <= 1'b0;
        burst_left      = 0;
        i_rst_n         <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset batch length: invalid numbers, four,
        // small and large primes, the all-ones number, composites with a
        // known answer and an increment that is a multiple of the number.
        send_number(64'd0, 64'd1);
        send_number(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'd4, 64'd1);
        send_number(64'd2, 64'd1);
        send_number(64'd37, 64'd3);
        send_number(64'd41, 64'd3);
        send_number(64'd2305843009213693951, 64'd1);
        send_number(64'hFFFF_FFFF_FFFF_FFC5, 64'd1);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'hFFFF_FFFF_FFFF_FFFE, 64'd1);
        send_number(64'd9, 64'd1);
        send_number(64'd25, 64'd75);
        send_number(64'd8051, 64'd1);
        send_number(64'd10403, 64'd2);
        send_number(64'd1763, 64'hAAAA_AAAA_5555_5555);
        send_number(64'd15, 64'd15);

        // Pause until everything is back, then fill the block while the
        // receiver holds off.
        drain_results();
        hold_req <= 1'b1;
        send_number(64'd4, 64'd1);
        send_number(64'd0, 64'd1);
        send_number(64'd91, 64'd1);
        send_number(64'd1, 64'd1);
        send_number(64'd35, 64'd2);
        send_number(64'd4, 64'd7);

        random_phase(11'd1, 14, 1'b1);
        random_phase(11'd0, 12, 1'b1);
        random_phase(11'd7, 14, 1'b1);
        random_phase(11'd1024, 10, 1'b0);
        random_phase(11'd2047, 10, 1'b0);
        random_phase(11'd33, 14, 1'b0);
        random_phase(prdf_pkg::BATCH_RESET, 14, 1'b1);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("pollard_rho_divisor_finder: match");
        else
            $display("pollard_rho_divisor_finder: mismatch");
        $finish;
    end

    initial begin
        #400000000;
        $display("pollard_rho_divisor_finder: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/prdf_pkg.sv
hw/rtl/prdf_if.sv
hw/rtl/prdf_dpath.sv
hw/rtl/prdf_ctrl.sv
hw/rtl/pollard_rho_divisor_finder.sv
tb/prdf_checker.sv
tb/testbench.sv
